/* design/ising_metropolis_spin_update_core_macros.svh */
// Assertion macros shared by the spin update core.
// Needs a clock named clock and a synchronous active-high reset named reset.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_CORE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset
`define ISING_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spin update core: same-cycle check failed");

// Next-cycle implication, checked on every clock edge out of reset
`define ISING_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spin update core: next-cycle check failed");

`endif

/* design/ising_pkg.sv */
// Shared widths, register indexes, reset values, limits and the row store control type
// for the spin update core. No dependencies.
package ising_pkg;

   // Default lattice capacity (side length)
   localparam int DEFAULT_MAX_SIDE = 64;

   // Field widths
   localparam int SITE_W     = 6;
   localparam int FRAC_W     = 16;
   localparam int MAG_W      = 14;
   localparam int SIDE_REG_W = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int AGREE_W    = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LATTICE_SIDE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THR_SMALL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THR_LARGE    = 2'd2;

   // Register reset values
   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 7'd64;
   localparam logic [FRAC_W-1:0]     THR_RESET  = 16'd0;

   // Smallest side in use
   localparam int MIN_SIDE = 2;

   // Neighbor agreement counts that select the acceptance rule
   localparam logic [AGREE_W-1:0] AGREE_SMALL = 3'd3;
   localparam logic [AGREE_W-1:0] AGREE_LARGE = 3'd4;

   // Row store control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } mem_ctrl_type;

endpackage

/* design/ising_row_store.sv */
// Lattice row store: one word of MAX_SIDE spins per row, registered read.
// Depends on ising_pkg. Row valid flops make unwritten rows read as all +1.
module ising_row_store #(
   parameter int MAX_SIDE = ising_pkg::DEFAULT_MAX_SIDE,
   localparam int IDX_W = $clog2(MAX_SIDE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ising_pkg::mem_ctrl_type  ctrl,
   input  logic [IDX_W-1:0]         rd_addr,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [MAX_SIDE-1:0]      wr_word,
   output logic [MAX_SIDE-1:0]      rd_word
);

   logic [MAX_SIDE-1:0] mem_ram [MAX_SIDE];
   logic [MAX_SIDE-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [MAX_SIDE-1:0] valid_ff;
   logic [MAX_SIDE-1:0] valid_in;

   // Write and read the spin rows
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ram[wr_addr] <= wr_word;
      end
      if (ctrl.rd_en) begin
         rd_data_ff  <= mem_ram[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Drop all rows on clear, mark a row valid once written
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = '0;
      end else if (ctrl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Unwritten rows hold all +1 spins
   assign rd_word = rd_valid_ff ? rd_data_ff : '1;

endmodule

/* design/ising_metropolis_spin_update_core.sv */
// Metropolis single-spin-flip core: a request is taken when start is high and busy low.
// A site outside the lattice is flagged from the address state; any other site runs the full sequence.
// One request at a time: busy stays high until the result is posted, through the sequencer steps of
// three registered row reads, the decision, the write-back and the return to idle.
// The receiver cannot stall; the strobe lasts one cycle.
// Reset (synchronous): side 64, thresholds 0, all spins +1, total side squared, no wait.
module ising_metropolis_spin_update_core #(
   parameter int MAX_SIDE = ising_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ising_pkg::SITE_W-1:0]          req_site_row,
   input  logic [ising_pkg::SITE_W-1:0]          req_site_col,
   input  logic [ising_pkg::FRAC_W-1:0]          req_rand_fraction,
   output logic                                  rsp_strobe,
   output logic                                  rsp_flipped,
   output logic                                  rsp_spin_after,
   output logic signed [ising_pkg::MAG_W-1:0]    rsp_magnet_sum,
   output logic                                  rsp_bad_site,
   input  logic                                  csr_we,
   input  logic [ising_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ising_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "ising_metropolis_spin_update_core_macros.svh"

   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CW     = (SIDE_W > ising_pkg::SIDE_REG_W) ? SIDE_W : ising_pkg::SIDE_REG_W;
   localparam int MAG_W  = ising_pkg::MAG_W;
   localparam int AW     = ising_pkg::AGREE_W;

   localparam int RESET_SIDE_USE = (int'(ising_pkg::SIDE_RESET) > MAX_SIDE) ?
                                   MAX_SIDE : int'(ising_pkg::SIDE_RESET);
   localparam logic [MAG_W-1:0] RESET_MAG  = MAG_W'(RESET_SIDE_USE * RESET_SIDE_USE);
   localparam logic [MAG_W-1:0] MAG_STEP   = MAG_W'(2);
   localparam logic [CW-1:0]    CW_ONE     = CW'(1);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADDR   = 3'd1;
   localparam logic [2:0] S_RD_UP  = 3'd2;
   localparam logic [2:0] S_RD_DN  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_WRITE  = 3'd5;

   // Clamp a side register value into the supported range
   function automatic logic [CW-1:0] side_clamp(input logic [ising_pkg::SIDE_REG_W-1:0] raw);
      logic [CW-1:0] ext;
      ext = CW'(raw);
      if (ext < CW'(ising_pkg::MIN_SIDE)) begin
         ext = CW'(ising_pkg::MIN_SIDE);
      end else if (ext > CW'(MAX_SIDE)) begin
         ext = CW'(MAX_SIDE);
      end
      return ext;
   endfunction

   logic [2:0]                        state_ff, state_in;
   logic [ising_pkg::SITE_W-1:0]      row_ff, row_in;
   logic [ising_pkg::SITE_W-1:0]      col_ff, col_in;
   logic [ising_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [IDX_W-1:0]                  up_ff, up_in;
   logic [IDX_W-1:0]                  dn_ff, dn_in;
   logic [IDX_W-1:0]                  left_ff, left_in;
   logic [IDX_W-1:0]                  right_ff, right_in;
   logic [MAX_SIDE-1:0]               word_ff, word_in;
   logic                              me_ff, me_in;
   logic [AW-1:0]                     agree_ff, agree_in;
   logic                              flip_ff, flip_in;
   logic [ising_pkg::SIDE_REG_W-1:0]  side_ff, side_in;
   logic [ising_pkg::FRAC_W-1:0]      thr_small_ff, thr_small_in;
   logic [ising_pkg::FRAC_W-1:0]      thr_large_ff, thr_large_in;
   logic [MAG_W-1:0]                  magnet_ff, magnet_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic                              rsp_flipped_ff, rsp_flipped_in;
   logic                              rsp_spin_ff, rsp_spin_in;
   logic [MAG_W-1:0]                  rsp_magnet_ff, rsp_magnet_in;
   logic                              rsp_bad_ff, rsp_bad_in;

   logic [CW-1:0]                     side_use, side_m1, row_ext, col_ext;
   logic [CW-1:0]                     up_w, dn_w, left_w, right_w;
   logic [CW-1:0]                     new_side;
   logic [2*CW-1:0]                   new_square;
   logic                              site_bad;
   logic [IDX_W-1:0]                  row_idx, col_idx;
   logic [AW-1:0]                     agree_fin;
   logic                              spin_new;

   ising_pkg::mem_ctrl_type           mem_ctrl;
   logic [IDX_W-1:0]                  mem_rd_addr;
   logic [MAX_SIDE-1:0]               mem_wr_word, mem_rd_word;

   // Site decode and periodic neighbor addresses
   always_comb begin
      side_use = side_clamp(side_ff);
      side_m1  = side_use - CW_ONE;
      row_ext  = CW'(row_ff);
      col_ext  = CW'(col_ff);
      site_bad = (row_ext >= side_use) || (col_ext >= side_use);
      up_w     = (row_ext == '0) ? side_m1 : row_ext - CW_ONE;
      dn_w     = (row_ext == side_m1) ? '0 : row_ext + CW_ONE;
      left_w   = (col_ext == '0) ? side_m1 : col_ext - CW_ONE;
      right_w  = (col_ext == side_m1) ? '0 : col_ext + CW_ONE;
      row_idx  = row_ext[IDX_W-1:0];
      col_idx  = col_ext[IDX_W-1:0];
   end

   // Side written through the register port and its square
   assign new_side   = side_clamp(csr_wdata[ising_pkg::SIDE_REG_W-1:0]);
   assign new_square = new_side * new_side;

   // Agreement counter input shared by the upper and lower neighbor counts, and the new spin
   assign agree_fin = agree_ff + AW'(mem_rd_word[col_idx] == me_ff);
   assign spin_new  = me_ff ^ flip_ff;

   // Row store access
   always_comb begin
      mem_ctrl.rd_en = (state_ff == S_ADDR) || (state_ff == S_RD_UP) || (state_ff == S_RD_DN);
      mem_ctrl.wr_en = (state_ff == S_WRITE) && flip_ff;
      mem_ctrl.clear = csr_we && (csr_index == ising_pkg::REG_LATTICE_SIDE);
      mem_rd_addr    = row_idx;
      if (state_ff == S_RD_UP) begin
         mem_rd_addr = up_ff;
      end else if (state_ff == S_RD_DN) begin
         mem_rd_addr = dn_ff;
      end
      mem_wr_word          = word_ff;
      mem_wr_word[col_idx] = spin_new;
   end

   ising_row_store #(
      .MAX_SIDE(MAX_SIDE)
   ) u_row_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mem_ctrl),
      .rd_addr (mem_rd_addr),
      .wr_addr (row_idx),
      .wr_word (mem_wr_word),
      .rd_word (mem_rd_word)
   );

   // Sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      frac_in        = frac_ff;
      up_in          = up_ff;
      dn_in          = dn_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      word_in        = word_ff;
      me_in          = me_ff;
      agree_in       = agree_ff;
      flip_in        = flip_ff;
      side_in        = side_ff;
      thr_small_in   = thr_small_ff;
      thr_large_in   = thr_large_ff;
      magnet_in      = magnet_ff;
      rsp_strobe_in  = 1'b0;
      rsp_flipped_in = rsp_flipped_ff;
      rsp_spin_in    = rsp_spin_ff;
      rsp_magnet_in  = rsp_magnet_ff;
      rsp_bad_in     = rsp_bad_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Take a request
            if (start) begin
               row_in   = req_site_row;
               col_in   = req_site_col;
               frac_in  = req_rand_fraction;
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            // Flag a site outside the lattice, else read the center row
            if (site_bad) begin
               rsp_strobe_in  = 1'b1;
               rsp_flipped_in = 1'b0;
               rsp_spin_in    = 1'b0;
               rsp_magnet_in  = magnet_ff;
               rsp_bad_in     = 1'b1;
               state_in       = S_IDLE;
            end else begin
               up_in    = up_w[IDX_W-1:0];
               dn_in    = dn_w[IDX_W-1:0];
               left_in  = left_w[IDX_W-1:0];
               right_in = right_w[IDX_W-1:0];
               state_in = S_RD_UP;
            end
         end
         S_RD_UP: begin
            // Hold the center row, count left and right agreement
            word_in  = mem_rd_word;
            me_in    = mem_rd_word[col_idx];
            agree_in = AW'(mem_rd_word[left_ff] == mem_rd_word[col_idx])
                     + AW'(mem_rd_word[right_ff] == mem_rd_word[col_idx]);
            state_in = S_RD_DN;
         end
         S_RD_DN: begin
            // Count the upper neighbor
            agree_in = agree_fin;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // Count the lower neighbor and apply the acceptance rule
            agree_in = agree_fin;
            flip_in  = (agree_fin < ising_pkg::AGREE_SMALL)
                     || ((agree_fin == ising_pkg::AGREE_SMALL) && (frac_ff < thr_small_ff))
                     || ((agree_fin == ising_pkg::AGREE_LARGE) && (frac_ff < thr_large_ff));
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // Write back the spin, advance the magnetization, post the result
            if (flip_ff) begin
               magnet_in = spin_new ? magnet_ff + MAG_STEP : magnet_ff - MAG_STEP;
            end
            rsp_strobe_in  = 1'b1;
            rsp_flipped_in = flip_ff;
            rsp_spin_in    = spin_new;
            rsp_magnet_in  = magnet_in;
            rsp_bad_in     = 1'b0;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes must arrive only while idle; the user is bound by this, the core does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            ising_pkg::REG_LATTICE_SIDE: begin
               side_in   = csr_wdata[ising_pkg::SIDE_REG_W-1:0];
               magnet_in = new_square[MAG_W-1:0];
            end
            ising_pkg::REG_THR_SMALL: begin
               thr_small_in = csr_wdata[ising_pkg::FRAC_W-1:0];
            end
            ising_pkg::REG_THR_LARGE: begin
               thr_large_in = csr_wdata[ising_pkg::FRAC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         side_ff       <= ising_pkg::SIDE_RESET;
         thr_small_ff  <= ising_pkg::THR_RESET;
         thr_large_ff  <= ising_pkg::THR_RESET;
         magnet_ff     <= RESET_MAG;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         side_ff       <= side_in;
         thr_small_ff  <= thr_small_in;
         thr_large_ff  <= thr_large_in;
         magnet_ff     <= magnet_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      col_ff         <= col_in;
      frac_ff        <= frac_in;
      up_ff          <= up_in;
      dn_ff          <= dn_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      word_ff        <= word_in;
      me_ff          <= me_in;
      agree_ff       <= agree_in;
      flip_ff        <= flip_in;
      rsp_flipped_ff <= rsp_flipped_in;
      rsp_spin_ff    <= rsp_spin_in;
      rsp_magnet_ff  <= rsp_magnet_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_flipped    = rsp_flipped_ff;
   assign rsp_spin_after = rsp_spin_ff;
   assign rsp_magnet_sum = signed'(rsp_magnet_ff);
   assign rsp_bad_site   = rsp_bad_ff;

   // A result is posted only once the sequencer is back to idle
   `ISING_ASSERT_IMP(a_strobe_when_idle, rsp_strobe_ff, state_ff == S_IDLE)
   // The strobe lasts a single cycle
   `ISING_ASSERT_NEXT(a_strobe_single, rsp_strobe_ff, !rsp_strobe_ff)
   // A flagged site reports no flip and spin -1
   `ISING_ASSERT_IMP(a_bad_quiet, rsp_strobe_ff && rsp_bad_ff,
                     !rsp_flipped_ff && !rsp_spin_ff)
   // Only sites inside the lattice reach the neighbor reads
   `ISING_ASSERT_IMP(a_site_inside, state_ff == S_RD_UP,
                     (row_ext < side_use) && (col_ext < side_use))
   // An accepted flip moves the magnetization
   `ISING_ASSERT_NEXT(a_flip_moves_total, (state_ff == S_WRITE) && flip_ff,
                      magnet_ff != $past(magnet_ff))

endmodule

/* tb/tb_ising_metropolis_spin_update_core.sv */
// Self-checking testbench for the Metropolis spin update core.
// Depends on ising_pkg and ising_metropolis_spin_update_core; keeps its own lattice predictor.
module tb_ising_metropolis_spin_update_core;

   localparam int GRID       = ising_pkg::DEFAULT_MAX_SIDE;
   localparam int SITE_W     = ising_pkg::SITE_W;
   localparam int FRAC_W     = ising_pkg::FRAC_W;
   localparam int MAG_W      = ising_pkg::MAG_W;
   localparam int SIDE_REG_W = ising_pkg::SIDE_REG_W;
   localparam int CSR_IDX_W  = ising_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = ising_pkg::CSR_DATA_W;
   localparam int PROD_SMALL = 2;   // energy rise 4J
   localparam int PROD_LARGE = 4;   // energy rise 8J
   localparam int PHASE_ITEMS = 210;

   typedef struct packed {
      logic             flipped;
      logic             spin_after;
      logic [MAG_W-1:0] magnet_sum;
      logic             bad_site;
   } spin_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [SITE_W-1:0]     req_site_row = '0;
   logic [SITE_W-1:0]     req_site_col = '0;
   logic [FRAC_W-1:0]     req_rand_fraction = '0;
   logic                  rsp_strobe;
   logic                  rsp_flipped;
   logic                  rsp_spin_after;
   logic signed [MAG_W-1:0] rsp_magnet_sum;
   logic                  rsp_bad_site;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted lattice and registers
   logic [GRID-1:0]       spin_rows [GRID];
   int                    lattice_magnet;
   logic [SIDE_REG_W-1:0] side_reg;
   logic [FRAC_W-1:0]     thr_small;
   logic [FRAC_W-1:0]     thr_large;

   spin_result_type pending_updates[$];
   int mismatches   = 0;
   int updates_sent = 0;
   int flips_seen   = 0;
   int bad_seen     = 0;

   ising_metropolis_spin_update_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_site_row(req_site_row), .req_site_col(req_site_col),
      .req_rand_fraction(req_rand_fraction),
      .rsp_strobe(rsp_strobe), .rsp_flipped(rsp_flipped), .rsp_spin_after(rsp_spin_after),
      .rsp_magnet_sum(rsp_magnet_sum), .rsp_bad_site(rsp_bad_site),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Side in use: register saturated into [MIN_SIDE, GRID]
   function automatic int active_side();
      int s;
      s = side_reg;
      if (s < ising_pkg::MIN_SIDE) s = ising_pkg::MIN_SIDE;
      if (s > GRID) s = GRID;
      return s;
   endfunction

   function automatic void refill_lattice();
      int s;
      s = active_side();
      for (int r = 0; r < GRID; r++) spin_rows[r] = '1;
      lattice_magnet = s * s;
   endfunction

   function automatic int spin_value(int r, int c);
      return spin_rows[r][c] ? 1 : -1;
   endfunction

   // Predict one Metropolis step and advance the lattice copy
   function automatic spin_result_type apply_metropolis(int row, int col,
                                                        logic [FRAC_W-1:0] frac);
      spin_result_type res;
      int s, up, down, left, right, me, nsum, prod;
      logic flip;
      s = active_side();
      res = '0;
      if (row >= s || col >= s) begin
         res.bad_site = 1'b1;
      end else begin
         up    = (row + s - 1) % s;
         down  = (row + 1) % s;
         left  = (col + s - 1) % s;
         right = (col + 1) % s;
         me    = spin_value(row, col);
         nsum  = spin_value(row, left) + spin_value(row, right)
               + spin_value(up, col) + spin_value(down, col);
         prod  = me * nsum;
         if (prod <= 0) flip = 1'b1;
         else if (prod == PROD_SMALL) flip = (frac < thr_small);
         else if (prod == PROD_LARGE) flip = (frac < thr_large);
         else flip = 1'b0;
         if (flip) begin
            me = -me;
            spin_rows[row][col] = (me > 0);
            lattice_magnet += 2 * me;
         end
         res.flipped    = flip;
         res.spin_after = (me > 0);
      end
      res.magnet_sum = lattice_magnet[MAG_W-1:0];
      return res;
   endfunction

   // Drive one request, hold start until it is taken, then queue its prediction.
   // Returns in the time step of the accepting edge with start still high.
   task automatic send_update(input int row, input int col, input logic [FRAC_W-1:0] frac);
      req_site_row      <= SITE_W'(row);
      req_site_col      <= SITE_W'(col);
      req_rand_fraction <= frac;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      pending_updates.push_back(apply_metropolis(row, col, frac));
      updates_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Let every expected result arrive and the core settle before a register write
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ising_pkg::REG_LATTICE_SIDE: begin
            side_reg = data[SIDE_REG_W-1:0];
            refill_lattice();
         end
         ising_pkg::REG_THR_SMALL: thr_small = data;
         ising_pkg::REG_THR_LARGE: thr_large = data;
         default: ;
      endcase
   endtask

   // Compare each strobed result with the oldest prediction
   always @(posedge clock) begin : check_results
      spin_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_updates.size() == 0) begin
            $error("unexpected result: flipped=%0d spin_after=%0d magnet_sum=%0d bad_site=%0d",
                   rsp_flipped, rsp_spin_after, rsp_magnet_sum, rsp_bad_site);
            mismatches++;
         end else begin
            want = pending_updates.pop_front();
            if (rsp_flipped !== want.flipped) begin
               $error("flipped: expected %0d, got %0d", want.flipped, rsp_flipped);
               mismatches++;
            end
            if (rsp_spin_after !== want.spin_after) begin
               $error("spin_after: expected %0d, got %0d", want.spin_after, rsp_spin_after);
               mismatches++;
            end
            if (rsp_magnet_sum !== want.magnet_sum) begin
               $error("magnet_sum: expected %0d, got %0d",
                      $signed(want.magnet_sum), rsp_magnet_sum);
               mismatches++;
            end
            if (rsp_bad_site !== want.bad_site) begin
               $error("bad_site: expected %0d, got %0d", want.bad_site, rsp_bad_site);
               mismatches++;
            end
            if (rsp_flipped === 1'b1) flips_seen++;
            if (rsp_bad_site === 1'b1) bad_seen++;
         end
      end
   end

   // Reset values: side 64, thresholds 0, lattice all up
   task automatic test_reset_state();
      send_update(0, 0, '0);
      send_update(GRID - 1, GRID - 1, '1);
      send_update(31, 17, FRAC_W'($urandom));
   endtask

   // Side register saturation and masking, with sites just outside the lattice
   task automatic test_side_saturation();
      write_reg(ising_pkg::REG_LATTICE_SIDE, 16'd0);
      send_update(1, 1, FRAC_W'($urandom));
      send_update(2, 0, FRAC_W'($urandom));
      send_update(0, GRID - 1, FRAC_W'($urandom));
      write_reg(ising_pkg::REG_LATTICE_SIDE, 16'hFF83);
      send_update(2, 2, FRAC_W'($urandom));
      send_update(3, 1, FRAC_W'($urandom));
      write_reg(ising_pkg::REG_LATTICE_SIDE, 16'd127);
      send_update(GRID - 1, 0, FRAC_W'($urandom));
      write_reg(ising_pkg::REG_LATTICE_SIDE, 16'd1);
      send_update(0, 1, FRAC_W'($urandom));
   endtask

   // Each acceptance rule at the threshold edges, plus wrapped neighbors
   task automatic test_flip_rules();
      write_reg(ising_pkg::REG_LATTICE_SIDE, 16'd4);
      write_reg(ising_pkg::REG_THR_SMALL, 16'd0);
      write_reg(ising_pkg::REG_THR_LARGE, 16'd0);
      send_update(1, 1, '0);
      write_reg(ising_pkg::REG_THR_LARGE, 16'hFFFF);
      send_update(1, 1, 16'hFFFF);
      send_update(1, 1, 16'hFFFE);
      send_update(1, 2, '0);
      write_reg(ising_pkg::REG_THR_SMALL, 16'hFFFF);
      send_update(1, 2, 16'hFFFF);
      send_update(1, 2, '0);
      send_update(1, 1, 16'hFFFF);
      send_update(2, 2, 16'h8000);
      send_update(0, 3, 16'h0001);
      send_update(3, 3, 16'h7FFF);
      send_update(3, 0, 16'hFFFF);
   endtask

   // Mostly valid sites with random content, some outside the lattice,
   // fractions now and then right at a threshold
   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] side_data,
                                   input logic [FRAC_W-1:0] small_thr,
                                   input logic [FRAC_W-1:0] large_thr,
                                   input bit idle_on);
      int s, row, col, burst_left;
      logic [FRAC_W-1:0] frac, pick;
      write_reg(ising_pkg::REG_LATTICE_SIDE, side_data);
      write_reg(ising_pkg::REG_THR_SMALL, small_thr);
      write_reg(ising_pkg::REG_THR_LARGE, large_thr);
      s = active_side();
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (s < GRID && $urandom_range(0, 9) == 0) begin
            row = $urandom_range(s, GRID - 1);
            col = $urandom_range(0, GRID - 1);
            if ($urandom_range(0, 1)) begin
               int t;
               t = row; row = col; col = t;
            end
         end else begin
            row = $urandom_range(0, s - 1);
            col = $urandom_range(0, s - 1);
         end
         frac = FRAC_W'($urandom);
         if ($urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, 1) ? thr_small : thr_large;
            frac = (pick != 0 && $urandom_range(0, 1)) ? pick - 1'b1 : pick;
         end
         send_update(row, col, frac);
         burst_left--;
         if (burst_left == 0) begin
            if (idle_on) pause_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
         end
      end
   endtask

   task automatic test_random_phases();
      run_random_phase(16'd64, FRAC_W'($urandom), FRAC_W'($urandom), 1'b1);
      run_random_phase(16'd2, 16'hFFFF, 16'h0000, 1'b1);
      run_random_phase(16'd5, FRAC_W'($urandom), FRAC_W'($urandom), 1'b0);
      run_random_phase(16'd16, 16'h0000, 16'hFFFF, 1'b1);
      run_random_phase(CSR_DATA_W'($urandom), FRAC_W'($urandom), FRAC_W'($urandom), 1'b1);
      run_random_phase(16'd64, 16'hFFFF, 16'hFFFF, 1'b0);
      run_random_phase(16'd3, 16'h4000, 16'h1000, 1'b1);
      run_random_phase(CSR_DATA_W'($urandom_range(2, 64)), FRAC_W'($urandom),
                       FRAC_W'($urandom), 1'b1);
   endtask

   initial begin
      int guard;
      side_reg  = ising_pkg::SIDE_RESET;
      thr_small = ising_pkg::THR_RESET;
      thr_large = ising_pkg::THR_RESET;
      refill_lattice();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_side_saturation();
      test_flip_rules();
      test_random_phases();

      // Drain outstanding results, then let the core settle
      start <= 1'b0;
      guard = 0;
      while (pending_updates.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (pending_updates.size() != 0) begin
         $error("%0d expected results never arrived", pending_updates.size());
         mismatches += pending_updates.size();
      end

      $display("covered %0d site updates across saturated, small and full lattice sides",
               updates_sent);
      $display("with both threshold rules at their edges: %0d flips, %0d bad sites",
               flips_seen, bad_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop in case the core hangs
   initial begin
      #2000000;
      $display("timeout waiting on the core");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
